// ===== rtl/pci_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color indexer package
// Shared types and constants for the palette cell chain and its controller.
// ----------------------------------------------------------------------------
package pci_pkg;

  localparam int IDX_W = 8;
  localparam int RGB_W = 24;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [RGB_W-1:0] rgb_t;

  localparam idx_t FULL_INDEX = 8'hFF;
  localparam logic [7:0] THR_RESET = 8'h7F;

  // Search or read token that walks down the cell chain.
  typedef struct packed {
    logic vld;
    logic rd;
    logic hit;
    idx_t idx;
    rgb_t rgb;
  } tok_t;

  // Broadcast palette write.
  typedef struct packed {
    logic en;
    idx_t idx;
    rgb_t rgb;
  } wr_t;

endpackage : pci_pkg
`default_nettype wire

// ===== rtl/pci_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Palette cell
// Holds one palette entry and passes the search or read token to its neighbor.
// ----------------------------------------------------------------------------
module pci_cell
  import pci_pkg::*;
#(
  parameter int CELL_IDX = 1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire rgb_t query_rgb,
  input  wire wr_t  wr,
  input  wire tok_t tok_in,
  output tok_t      tok_out
);

  localparam idx_t MY_IDX = idx_t'(CELL_IDX);

  rgb_t entry_r;
  logic used_r;
  tok_t tok_r;
  tok_t tok_nxt;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld) begin
      if (tok_in.rd) begin
        if (tok_in.idx == MY_IDX) begin
          tok_nxt.rgb = used_r ? entry_r : '0;
        end
      end else if (!tok_in.hit && used_r && (entry_r == query_rgb)) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.idx = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      used_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      if (wr.en && (wr.idx == MY_IDX)) begin
        used_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == MY_IDX)) begin
      entry_r <= wr.rgb;
    end
  end

  assign tok_out = tok_r;

endmodule : pci_cell
`default_nettype wire

// ===== rtl/palette_color_indexer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Palette color indexer
// Maps RGBA pixels to palette indices while building the palette.
// ----------------------------------------------------------------------------
// The input channel carries one pixel or palette read per transaction; in_tuser
// selects a read. The output channel returns one result per input transaction.
// The alpha threshold is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, which the block itself does not enforce.
// Each palette slot from 1 up lives in its own cell; a token walks the row of
// PALETTE_ENTRIES-1 cells, one cell per cycle, matching the color or picking up
// the requested entry. The token passes the inject register and each cell
// register, then the result is registered; the next input is taken once it has
// moved to the output register. One item is in flight at a time.
// When the receiver stalls, the finished result waits in the output register
// and a second result waits in a holding register; input is then held off.
// Reset clears the slot valid bits at once, sets the count to one and the
// threshold to 127; no clearing pass is needed.
// ----------------------------------------------------------------------------
module palette_color_indexer_top
  import pci_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // red, green, blue, alpha, entry_index
  input  wire logic        in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // color_index, new_entry, palette_full, entry_red, entry_green, entry_blue,
  // entries_used, zero fill
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  localparam int   MAX_USED   = (PALETTE_ENTRIES < 255) ? PALETTE_ENTRIES : 255;
  localparam idx_t MAX_USED_C = idx_t'(MAX_USED);
  localparam int   NCELL      = PALETTE_ENTRIES - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  thr_r;
  idx_t        count_r, count_nxt;
  rgb_t        q_rgb_r;
  logic        transp_r;
  tok_t        inj_r, inj_nxt;
  logic [47:0] res_r, res_nxt;
  logic [47:0] out_r;
  logic        out_vld_r;
  wr_t         wr;
  tok_t        link [0:NCELL];
  tok_t        tail;
  logic [NCELL:0] link_vld;
  logic        in_acc;
  logic        out_free;

  idx_t        res_idx;
  logic        res_new;
  logic        res_full;
  rgb_t        res_rgb;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign in_tready = rst_n && (state_r == ST_IDLE);

  assign link[0] = inj_r;
  assign tail    = link[NCELL];

  genvar gi;
  generate
    for (gi = 1; gi <= NCELL; gi++) begin : g_cell
      pci_cell #(
        .CELL_IDX(gi)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .query_rgb(q_rgb_r),
        .wr       (wr),
        .tok_in   (link[gi-1]),
        .tok_out  (link[gi])
      );
    end
    for (gi = 0; gi <= NCELL; gi++) begin : g_vld
      assign link_vld[gi] = link[gi].vld;
    end
  endgenerate

  always_comb begin
    inj_nxt     = '0;
    inj_nxt.vld = in_acc;
    inj_nxt.rd  = in_tuser;
    inj_nxt.idx = in_tdata[39:32];
  end

  always_comb begin
    res_idx   = '0;
    res_new   = 1'b0;
    res_full  = 1'b0;
    res_rgb   = '0;
    count_nxt = count_r;
    wr        = '0;
    if ((state_r == ST_SCAN) && tail.vld) begin
      if (tail.rd) begin
        res_rgb = tail.rgb;
      end else if (!transp_r) begin
        if (tail.hit) begin
          res_idx = tail.idx;
        end else if (count_r < MAX_USED_C) begin
          res_idx   = count_r;
          res_new   = 1'b1;
          count_nxt = count_r + 8'd1;
          wr.en     = 1'b1;
          wr.idx    = count_r;
          wr.rgb    = q_rgb_r;
        end else begin
          res_idx  = FULL_INDEX;
          res_full = 1'b1;
        end
      end
    end
    res_nxt = {6'd0, count_nxt, res_rgb[7:0], res_rgb[15:8], res_rgb[23:16],
               res_full, res_new, res_idx};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.vld) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      thr_r     <= THR_RESET;
      count_r   <= 8'd1;
      inj_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      inj_r   <= inj_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if ((state_r == ST_HOLD) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_rgb_r  <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
      transp_r <= (in_tdata[31:24] < thr_r);
    end
    if ((state_r == ST_SCAN) && tail.vld) begin
      res_r <= res_nxt;
    end
    if ((state_r == ST_HOLD) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

`ifndef SYNTH
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(link_vld) <= 1)
    else $error("more than one token in the cell chain");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (state_r == ST_SCAN))
    else $error("token left the chain outside a scan");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (count_r == $past(count_r) + 8'd1) && (count_r <= MAX_USED_C))
    else $error("palette count did not advance by one on insert");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (link_vld == '0))
    else $error("input accepted while a token is in flight");
`endif

endmodule : palette_color_indexer_top
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Palette color indexer testbench
// Sends pixel and palette-read transactions with random gaps on both sides,
// keeps its own copy of the palette, the entry count and the alpha threshold,
// and checks every result transaction field by field against that copy.
// ----------------------------------------------------------------------------
module testbench
  import pci_pkg::*;
;

  localparam int PALETTE_ENTRIES = 256;
  localparam int MAX_USED = (PALETTE_ENTRIES < 255) ? PALETTE_ENTRIES : 255;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1450;

  typedef enum logic {
    ACT_CLASSIFY = 1'b0,
    ACT_READ     = 1'b1
  } action_e;

  typedef struct {
    action_e    action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    idx_t       entry_index;
  } pixel_req_t;

  typedef struct packed {
    idx_t       color_index;
    logic       new_entry;
    logic       palette_full;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
    idx_t       entries_used;
  } pixel_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  rgb_t        pal_rgb [PALETTE_ENTRIES];
  int          pal_used;
  logic [7:0]  alpha_thr;
  pixel_res_t  pending_results [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          ready_hold = 0;
  logic        no_idle = 1'b0;

  always #6 clk = ~clk;

  palette_color_indexer_top #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_res_t classify_and_index(input pixel_req_t req);
    pixel_res_t res;
    rgb_t       rgb;
    rgb_t       stored;
    logic       hit;
    res = '0;
    stored = '0;
    hit = 1'b0;
    if (req.action == ACT_READ) begin
      if (int'(req.entry_index) < PALETTE_ENTRIES) stored = pal_rgb[req.entry_index];
      res.entry_red   = stored[23:16];
      res.entry_green = stored[15:8];
      res.entry_blue  = stored[7:0];
    end else if (req.alpha >= alpha_thr) begin
      rgb = {req.red, req.green, req.blue};
      for (int i = 1; i < pal_used; i++) begin
        if (!hit && pal_rgb[i] == rgb) begin
          res.color_index = idx_t'(i);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (pal_used < MAX_USED) begin
          res.color_index = idx_t'(pal_used);
          pal_rgb[pal_used] = rgb;
          pal_used++;
          res.new_entry = 1'b1;
        end else begin
          res.color_index = FULL_INDEX;
          res.palette_full = 1'b1;
        end
      end
    end
    res.entries_used = idx_t'(pal_used);
    return res;
  endfunction

  function automatic pixel_req_t make_pixel(input rgb_t rgb, input logic [7:0] alpha);
    pixel_req_t req;
    req.action = ACT_CLASSIFY;
    {req.red, req.green, req.blue} = rgb;
    req.alpha = alpha;
    req.entry_index = idx_t'($urandom_range(0, 255));
    return req;
  endfunction

  function automatic pixel_req_t make_read(input idx_t slot);
    pixel_req_t req;
    req = make_pixel(rgb_t'($urandom), 8'($urandom_range(0, 255)));
    req.action = ACT_READ;
    req.entry_index = slot;
    return req;
  endfunction

  // Most opaque pixels reuse a stored color or a one-bit neighbor of one, so
  // hits, near misses and appends all occur.
  function automatic pixel_req_t random_pixel();
    pixel_req_t req;
    rgb_t       rgb;
    logic [7:0] alpha;
    int         r;
    int         flip;
    r = $urandom_range(0, 99);
    rgb = rgb_t'($urandom);
    if ($urandom_range(0, 3) == 0) alpha = 8'($urandom_range(0, 255));
    else alpha = 8'($urandom_range(alpha_thr, 255));
    if (r < 12) return make_read(idx_t'($urandom_range(0, 255)));
    if (r < 60 && pal_used > 1) begin
      rgb = pal_rgb[$urandom_range(1, pal_used - 1)];
    end else if (r < 70 && pal_used > 1) begin
      flip = $urandom_range(0, 23);
      rgb = pal_rgb[$urandom_range(1, pal_used - 1)];
      rgb[flip] = ~rgb[flip];
    end
    req = make_pixel(rgb, alpha);
    return req;
  endfunction

  task automatic send_pixel(input pixel_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.action;
    in_tdata  <= {req.entry_index, req.alpha, req.blue, req.green, req.red};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(classify_and_index(req));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [7:0] level);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= level;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    alpha_thr = level;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic test_directed();
    send_pixel(make_read(8'd0));
    send_pixel(make_read(8'd255));
    send_pixel(make_read(8'd1));
    send_pixel(make_pixel(24'hFFFFFF, 8'd126));
    send_pixel(make_pixel(24'h000000, 8'd127));
    send_pixel(make_pixel(24'hFFFFFF, 8'd255));
    send_pixel(make_pixel(24'h000000, 8'd200));
    send_pixel(make_pixel(24'hFFFFFF, 8'd0));
    send_pixel(make_pixel(24'h123456, 8'd128));
    send_pixel(make_pixel(24'hFFFFFE, 8'd255));
    send_pixel(make_pixel(24'hFFFFFF, 8'd127));
    send_pixel(make_pixel(24'hAA55A5, 8'd255));
    send_pixel(make_pixel(24'h55AA5A, 8'd255));
    for (int s = 1; s <= 7; s++) send_pixel(make_read(idx_t'(s)));
    send_pixel(make_read(8'd128));
    send_pixel(make_pixel(24'h123456, 8'd255));
    send_pixel(make_pixel(24'hAA55A5, 8'd255));
  endtask

  task automatic test_threshold();
    int levels [$];
    levels = '{0, 255, 1, 254, $urandom_range(2, 253), 127};
    foreach (levels[k]) begin
      set_threshold(8'(levels[k]));
      if (levels[k] > 0) send_pixel(make_pixel(rgb_t'($urandom), 8'(levels[k] - 1)));
      send_pixel(make_pixel(rgb_t'($urandom), 8'(levels[k])));
      if (levels[k] < 255) send_pixel(make_pixel(rgb_t'($urandom), 8'(levels[k] + 1)));
      repeat (6) send_pixel(random_pixel());
    end
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) no_idle <= ((n / 100) % 4 == 3);
      if (n % 200 == 199) set_threshold(8'($urandom_range(0, 255)));
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_pixel(random_pixel());
    end
    no_idle <= 1'b0;
  endtask

  task automatic test_palette_full();
    while (pal_used < MAX_USED) send_pixel(make_pixel(rgb_t'($urandom), 8'hFF));
    repeat (4) send_pixel(make_pixel(rgb_t'($urandom), 8'hFF));
    send_pixel(make_pixel(pal_rgb[MAX_USED - 1], 8'hFF));
    send_pixel(make_pixel(pal_rgb[1], 8'hFF));
    send_pixel(make_read(idx_t'(MAX_USED - 1)));
    send_pixel(make_read(8'd255));
    send_pixel(make_read(8'd0));
    repeat (120) send_pixel(random_pixel());
  endtask

  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  always @(posedge clk) begin : check_results
    pixel_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no pixel pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("color_index", want.color_index, out_tdata[7:0]);
        check_field("new_entry", want.new_entry, out_tdata[8]);
        check_field("palette_full", want.palette_full, out_tdata[9]);
        check_field("entry_red", want.entry_red, out_tdata[17:10]);
        check_field("entry_green", want.entry_green, out_tdata[25:18]);
        check_field("entry_blue", want.entry_blue, out_tdata[33:26]);
        check_field("entries_used", want.entries_used, out_tdata[41:34]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < PALETTE_ENTRIES; i++) pal_rgb[i] = '0;
    pal_used = 1;
    alpha_thr = THR_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_threshold();
    test_random_stream();
    test_palette_full();
    drain_results();
    repeat (PALETTE_ENTRIES + 4) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
